@@ rtl/core/skrf_pkg.sv @@
`timescale 1ns / 1ps

package skrf_pkg;

  // Fixed field widths
  localparam int IN_W       = 12;  // sample_i / sample_q field width
  localparam int THR_W      = 16;  // Q4.12 threshold width
  localparam int WLEN_CFG_W = 11;  // window_length register width
  localparam int CNT_OUT_W  = 16;  // count fields on the result channel
  localparam int FRAC_BITS  = 12;  // fractional bits of the thresholds
  localparam int DIGIT_W    = 4;   // multiplier digit per step
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF       = 12;
  localparam int MAX_WINDOW_LENGTH_DEF = 1024;
  localparam int COUNT_BITS_DEF        = 16;

  // Register reset values
  localparam logic [WLEN_CFG_W-1:0] RST_WINDOW_LENGTH = 11'd256;
  localparam logic [THR_W-1:0]      RST_KURT_LOW      = 16'd3277;
  localparam logic [THR_W-1:0]      RST_KURT_HIGH     = 16'd4915;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_KURT_LOW      = 2'd1,
    REG_KURT_HIGH     = 2'd2
  } cfg_reg_t;

  // Products formed by the shared multiplier, in evaluation order
  typedef enum logic [2:0] {
    OP_S1SQ,  // S1 * S1
    OP_MS2,   // M * S2
    OP_LHS,   // (M*S2 - S1^2) * (M+1)
    OP_HI,    // S1^2 * (M-1) * high
    OP_LO     // S1^2 * (M-1) * low
  } mul_op_t;

  typedef struct packed {
    logic    mul_start;
    mul_op_t mul_op;
    logic    emit;
    logic    win_closed;
    logic    blk_last;
    logic    flag;
  } skrf_cmd_t;

  typedef struct packed {
    logic close_now;   // sample on the input would complete the window
    logic blk_end;     // block_end of the sample on the input
    logic pipe_busy;   // power pipeline still holds samples
    logic mul_busy;
    logic s1_zero;
    logic ms2_below;   // M*S2 < S1^2
    logic above_hi;
    logic below_lo;
  } skrf_sts_t;

endpackage

@@ rtl/core/skrf_ifs.sv @@
`timescale 1ns / 1ps

interface skrf_in_if import skrf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample_i;
  logic signed [IN_W-1:0] sample_q;
  logic                   block_end;

  modport source (output valid, output sample_i, output sample_q, output block_end,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input block_end,
                  output ready);
endinterface

interface skrf_out_if import skrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 window_flag;
  logic [CNT_OUT_W-1:0] flagged_count;
  logic [CNT_OUT_W-1:0] window_count;
  logic                 block_done;
  logic                 block_status;

  modport source (output valid, output window_flag, output flagged_count,
                  output window_count, output block_done, output block_status,
                  input ready);
  modport sink   (input valid, input window_flag, input flagged_count,
                  input window_count, input block_done, input block_status,
                  output ready);
endinterface

@@ rtl/core/skrf_datapath.sv @@
`timescale 1ns / 1ps

module skrf_datapath import skrf_pkg::*; #(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LENGTH = MAX_WINDOW_LENGTH_DEF,
  parameter int COUNT_BITS        = COUNT_BITS_DEF,
  localparam int LEN_W            = $clog2(MAX_WINDOW_LENGTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic [IN_W-1:0]        sample_i,
  input  logic [IN_W-1:0]        sample_q,
  input  logic                   block_end,
  input  logic [LEN_W-1:0]       win_len,
  input  logic [THR_W-1:0]       thr_low,
  input  logic [THR_W-1:0]       thr_high,
  input  skrf_cmd_t              cmd,
  output skrf_sts_t              sts,
  output logic                   out_flag,
  output logic [CNT_OUT_W-1:0]   out_flagged,
  output logic [CNT_OUT_W-1:0]   out_windows,
  output logic                   out_done,
  output logic                   out_status
);

  localparam int PWR_W  = 2 * SAMPLE_BITS;
  localparam int SQ_W   = 2 * PWR_W;
  localparam int S1_W   = PWR_W + LEN_W;
  localparam int S2_W   = SQ_W + LEN_W;
  localparam int WIDE_W = 2 * S1_W;
  localparam int K_W    = LEN_W + THR_W;
  localparam int B_W    = (S1_W > K_W) ? S1_W : K_W;
  localparam int PROD_W = WIDE_W + B_W;
  localparam int CMP_W  = PROD_W + FRAC_BITS;
  localparam int EXT_W  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // power of the incoming sample
  logic signed [SAMPLE_BITS-1:0] si, sq;
  logic signed [PWR_W-1:0]       si_x, sq_x, si_sq, sq_sq;
  logic [PWR_W-1:0]              pwr;

  assign si    = $signed(sample_i[SAMPLE_BITS-1:0]);
  assign sq    = $signed(sample_q[SAMPLE_BITS-1:0]);
  assign si_x  = PWR_W'(si);
  assign sq_x  = PWR_W'(sq);
  assign si_sq = si_x * si_x;
  assign sq_sq = sq_x * sq_x;
  assign pwr   = $unsigned(si_sq) + $unsigned(sq_sq);

  logic                 pv1_r, pv2_r;
  logic [PWR_W-1:0]     pwr_r;
  logic [SQ_W-1:0]      sq_r;
  logic [S1_W-1:0]      s1_r;
  logic [S2_W-1:0]      s2_r;
  logic [LEN_W-1:0]     pos_r;
  logic [LEN_W:0]       pos_inc;
  logic [COUNT_BITS-1:0] done_r, flg_r, done_nxt, flg_nxt;

  assign pos_inc = {1'b0, pos_r} + 1'b1;

  // shared digit-serial multiplier
  logic                 mul_busy_r;
  logic [PROD_W-1:0]    a_r, acc_r, part;
  logic [B_W-1:0]       b_r;
  logic [WIDE_W-1:0]    s1sq_r;
  logic [PROD_W-1:0]    lhs_r;
  logic [LEN_W:0]       m_inc;
  logic [K_W-1:0]       k_hi, k_lo;
  logic [CMP_W-1:0]     lhs_sh, acc_x;

  assign m_inc = {1'b0, win_len} + 1'b1;
  assign k_hi  = K_W'(win_len - 1'b1) * K_W'(thr_high);
  assign k_lo  = K_W'(win_len - 1'b1) * K_W'(thr_low);
  assign part  = a_r * PROD_W'(b_r[DIGIT_W-1:0]);

  assign lhs_sh = {lhs_r, {FRAC_BITS{1'b0}}};
  assign acc_x  = CMP_W'(acc_r);

  always_comb begin
    sts.close_now = pos_inc >= m_inc - 1'b1;
    sts.blk_end   = block_end;
    sts.pipe_busy = pv1_r | pv2_r;
    sts.mul_busy  = mul_busy_r;
    sts.s1_zero   = (s1_r == '0);
    sts.ms2_below = acc_r < PROD_W'(s1sq_r);
    sts.above_hi  = lhs_sh > acc_x;
    sts.below_lo  = lhs_sh < acc_x;
  end

  // saturating window counts
  always_comb begin
    done_nxt = done_r;
    flg_nxt  = flg_r;
    if (cmd.win_closed && done_r != CNT_MAX) begin
      done_nxt = done_r + 1'b1;
    end
    if (cmd.win_closed && cmd.flag && flg_r != CNT_MAX) begin
      flg_nxt = flg_r + 1'b1;
    end
  end

  logic [EXT_W-1:0] done_ext, flg_ext;
  assign done_ext = EXT_W'(done_nxt);
  assign flg_ext  = EXT_W'(flg_nxt);

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv1_r      <= 1'b0;
      pv2_r      <= 1'b0;
      pos_r      <= '0;
      s1_r       <= '0;
      s2_r       <= '0;
      done_r     <= '0;
      flg_r      <= '0;
      mul_busy_r <= 1'b0;
    end else begin
      pv1_r <= in_fire;
      pv2_r <= pv1_r;
      if (in_fire) begin
        pos_r <= sts.close_now ? '0 : pos_inc[LEN_W-1:0];
      end
      if (cmd.emit) begin
        s1_r  <= '0;
        s2_r  <= '0;
        pos_r <= '0;
        if (cmd.blk_last) begin
          done_r <= '0;
          flg_r  <= '0;
        end else begin
          done_r <= done_nxt;
          flg_r  <= flg_nxt;
        end
      end else begin
        if (pv1_r) begin
          s1_r <= s1_r + S1_W'(pwr_r);
        end
        if (pv2_r) begin
          s2_r <= s2_r + S2_W'(sq_r);
        end
      end
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
      end else if (mul_busy_r && b_r == '0) begin
        mul_busy_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pwr_r <= pwr;
    end
    sq_r <= SQ_W'(pwr_r) * SQ_W'(pwr_r);

    if (cmd.mul_start) begin
      acc_r <= '0;
      case (cmd.mul_op)
        OP_S1SQ: begin
          a_r <= PROD_W'(s1_r);
          b_r <= B_W'(s1_r);
        end
        OP_MS2: begin
          s1sq_r <= acc_r[WIDE_W-1:0];
          a_r    <= PROD_W'(s2_r);
          b_r    <= B_W'(win_len);
        end
        OP_LHS: begin
          a_r <= PROD_W'(acc_r[WIDE_W-1:0] - s1sq_r);
          b_r <= B_W'(m_inc);
        end
        OP_HI: begin
          lhs_r <= acc_r;
          a_r   <= PROD_W'(s1sq_r);
          b_r   <= B_W'(k_hi);
        end
        OP_LO: begin
          a_r <= PROD_W'(s1sq_r);
          b_r <= B_W'(k_lo);
        end
        default: begin
          a_r <= '0;
          b_r <= '0;
        end
      endcase
    end else if (mul_busy_r && b_r != '0) begin
      acc_r <= acc_r + part;
      a_r   <= a_r << DIGIT_W;
      b_r   <= b_r >> DIGIT_W;
    end

    if (cmd.emit) begin
      out_flag    <= cmd.flag;
      out_flagged <= (flg_ext > EXT_W'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                           : flg_ext[CNT_OUT_W-1:0];
      out_windows <= (done_ext > EXT_W'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                            : done_ext[CNT_OUT_W-1:0];
      out_done    <= cmd.blk_last;
      out_status  <= cmd.blk_last & ~cmd.win_closed;
    end
  end

endmodule

@@ rtl/core/skrf_ctrl.sv @@
`timescale 1ns / 1ps

module skrf_ctrl import skrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  skrf_sts_t sts,
  output skrf_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_EMIT
  } state_t;

  state_t  state_r;
  mul_op_t op_r;
  logic    flag_r, win_closed_r, blk_last_r, out_valid_r;
  logic    slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.mul_op     = op_r;
    cmd.flag       = flag_r;
    cmd.win_closed = win_closed_r;
    cmd.blk_last   = blk_last_r;
    cmd.mul_start  = (state_r == ST_MUL_GO);
    cmd.emit       = (state_r == ST_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      op_r         <= OP_S1SQ;
      flag_r       <= 1'b0;
      win_closed_r <= 1'b0;
      blk_last_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (in_valid) begin
            win_closed_r <= sts.close_now;
            blk_last_r   <= sts.blk_end;
            flag_r       <= 1'b0;
            if (sts.close_now || sts.blk_end) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!sts.pipe_busy) begin
            if (!win_closed_r || sts.s1_zero) begin
              state_r <= ST_EMIT;
            end else begin
              op_r    <= OP_S1SQ;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: begin
          state_r <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (!sts.mul_busy) begin
            case (op_r)
              OP_S1SQ: begin
                op_r    <= OP_MS2;
                state_r <= ST_MUL_GO;
              end
              OP_MS2: begin
                if (sts.ms2_below) begin
                  flag_r  <= 1'b1;
                  state_r <= ST_EMIT;
                end else begin
                  op_r    <= OP_LHS;
                  state_r <= ST_MUL_GO;
                end
              end
              OP_LHS: begin
                op_r    <= OP_HI;
                state_r <= ST_MUL_GO;
              end
              OP_HI: begin
                if (sts.above_hi) begin
                  flag_r  <= 1'b1;
                  state_r <= ST_EMIT;
                end else begin
                  op_r    <= OP_LO;
                  state_r <= ST_MUL_GO;
                end
              end
              OP_LO: begin
                flag_r  <= sts.below_lo;
                state_r <= ST_EMIT;
              end
              default: begin
                state_r <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/spectral_kurtosis_rfi_flagger.sv @@
`timescale 1ns / 1ps

// Spectral kurtosis RFI flagger. Complex I/Q samples stream in; every window of
// M samples (window_length, clamped to 2..MAX_WINDOW_LENGTH) gives one result
// transaction saying whether SK = (M+1)/(M-1)*(M*S2/S1^2 - 1) lies outside the
// Q4.12 thresholds [kurtosis_low, kurtosis_high], together with running
// flagged and window counts for the current block. The test is exact: it is
// done by cross-multiplication, never by dividing. A window with zero power is
// never flagged; a negative estimate (only after a length change) counts as
// below the low threshold. block_end on a sample closes the block: its result
// has block_done set, and block_status set if the block stopped mid-window
// (that partial window is thrown away). Counts and sums clear after the block.
// Rate: samples that close neither a window nor a block stream at one per
// clock. A window-closing sample stalls the input while the sums drain from
// the two-stage power pipeline and a single 4-bit digit-serial multiplier
// forms up to five wide products in turn, fewer when the decision is settled
// early. A block end mid-window, or a window with no power, holds the input
// only while the pipeline drains and the result is emitted, with no products
// formed. Results wait in an output register, so a stalled sink only holds
// things up at the next result.
// Configuration may be written only while the block is idle.

module spectral_kurtosis_rfi_flagger import skrf_pkg::*; #(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LENGTH = MAX_WINDOW_LENGTH_DEF,
  parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  skrf_in_if.sink               in_ch,
  skrf_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_WINDOW_LENGTH + 1);
  localparam logic [WLEN_CFG_W-1:0] LEN_MIN = WLEN_CFG_W'(2);
  localparam logic [WLEN_CFG_W-1:0] LEN_MAX = WLEN_CFG_W'(MAX_WINDOW_LENGTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WLEN_CFG_W-1:0] window_length_r;
  logic [THR_W-1:0]      kurt_low_r, kurt_high_r;
  logic [LEN_W-1:0]      win_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= RST_WINDOW_LENGTH;
      kurt_low_r      <= RST_KURT_LOW;
      kurt_high_r     <= RST_KURT_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WLEN_CFG_W-1:0];
        REG_KURT_LOW:      kurt_low_r      <= cfg_wdata[THR_W-1:0];
        REG_KURT_HIGH:     kurt_high_r     <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective M: out-of-range lengths are pulled to the nearest limit
  always_comb begin
    if (window_length_r < LEN_MIN) begin
      win_len = LEN_W'(LEN_MIN);
    end else if (window_length_r > LEN_MAX) begin
      win_len = LEN_W'(LEN_MAX);
    end else begin
      win_len = window_length_r[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Controller and datapath
  // ---------------------------------------------------------------------------
  skrf_cmd_t cmd;
  skrf_sts_t sts;
  logic      in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  skrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  skrf_datapath #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .MAX_WINDOW_LENGTH (MAX_WINDOW_LENGTH),
    .COUNT_BITS        (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .sample_i    (in_ch.sample_i),
    .sample_q    (in_ch.sample_q),
    .block_end   (in_ch.block_end),
    .win_len     (win_len),
    .thr_low     (kurt_low_r),
    .thr_high    (kurt_high_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_flag    (out_ch.window_flag),
    .out_flagged (out_ch.flagged_count),
    .out_windows (out_ch.window_count),
    .out_done    (out_ch.block_done),
    .out_status  (out_ch.block_status)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // no sample taken while the multiplier works on a closed window
  a_no_accept_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_busy |-> !in_ch.ready)
    else $error("sample accepted during window evaluation");

  // flagged windows never outnumber completed ones
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.flagged_count <= out_ch.window_count)
    else $error("flagged count above window count");

  // a mid-window block end is a block-closing, unflagged result
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.block_status) |-> (out_ch.block_done && !out_ch.window_flag))
    else $error("bad mid-window block end result");

  // every emitted result is presented on the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

endmodule
